// ----- sv/lis_pkg.sv -----
// Shared types and constants for the longest increasing subsequence block.
`default_nettype none

package lis_pkg;

    localparam int VALUE_W = 32;
    localparam int LEN_W   = 7;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    // Input transfer payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } lis_in_t;

    // Result transfer payload
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } lis_out_t;

    // Status handed from one cell to its right neighbor
    typedef struct packed {
        logic valid;  // cell holds a tail
        logic ge;     // held tail >= incoming value
    } lis_link_t;

endpackage

`default_nettype wire

// ----- sv/lis_cell.sv -----
// One tail cell of the sorted chain: holds a tail, compares, and takes the value when it is its slot.
`default_nettype none

module lis_cell
    import lis_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      insert,
    input  wire logic                      clear,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire lis_link_t                 left,
    output lis_link_t                      right,
    output logic                           grow
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] tail_reg;
    logic                      here_ge;
    logic                      take;

    // Tails are strictly increasing, so the first cell that is >= value is
    // the one whose left neighbor is not; an append lands on the first empty cell.
    assign here_ge = valid_reg && (tail_reg >= value);
    assign take    = insert && !left.ge &&
                     (here_ge || (!valid_reg && left.valid));
    assign grow    = take && !valid_reg;

    assign right.valid = valid_reg;
    assign right.ge    = here_ge;

    // Valid bit: set on a write, cleared after the final item of a sequence
    always_comb begin
        valid_next = valid_reg;
        if (insert && clear) begin
            valid_next = 1'b0;
        end else if (take) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Tail payload, no reset needed
    always_ff @(posedge aclk) begin
        if (take) begin
            tail_reg <= value;
        end
    end

endmodule

`default_nettype wire

// ----- sv/longest_increasing_subsequence.sv -----
// The result reaches the output register in the cycle after the input transfer.
// One item per cycle unless the output stalls; every cell of the tail chain compares in
// parallel, each deciding from its left neighbor's status alone.
// Reset (aresetn low, synchronous) empties all cells, zeroes the count and drops
// any pending result. The final item of a sequence empties the chain after its result.
`default_nettype none

module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire lis_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output lis_out_t     m_data
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    lis_link_t            link [0:MAX_LEN];
    logic [MAX_LEN-1:0]   grow_vec;
    logic [MAX_LEN-1:0]   valid_vec;
    logic                 insert;
    logic                 grew;
    logic                 overflow;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        count_after;
    logic [LW-1:0]        len_wide;
    logic [LEN_W-1:0]     len_sat;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    lis_out_t             m_data_reg;

    // Accept while the result register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign insert  = s_valid && s_ready;

    // Head of the chain acts as a full cell smaller than any value
    assign link[0] = '{valid: 1'b1, ge: 1'b0};

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lis_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .insert  (insert),
            .clear   (s_data.last),
            .value   (s_data.value),
            .left    (link[i]),
            .right   (link[i+1]),
            .grow    (grow_vec[i])
        );
        assign valid_vec[i] = link[i+1].valid;
    end

    // Store full and even the largest tail is below the value: dropped
    assign overflow    = link[MAX_LEN].valid && !link[MAX_LEN].ge;
    assign grew        = |grow_vec;
    assign count_after = count_reg + CW'(grew);

    // Length saturates at the field's maximum
    assign len_wide = LW'(count_after);
    assign len_sat  = (len_wide > LW'(LEN_SAT)) ? LEN_SAT : len_wide[LEN_W-1:0];

    // Tail count
    always_comb begin
        count_next = count_reg;
        if (insert) begin
            count_next = s_data.last ? '0 : count_after;
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (insert) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (insert) begin
            m_data_reg.length   <= len_sat;
            m_data_reg.overflow <= overflow;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Count always matches the number of occupied cells
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("tail count disagrees with occupied cells");

    // A dropped value can only happen with a full store
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (insert && overflow) |-> (int'(count_reg) == MAX_LEN && !grew))
        else $error("overflow without a full store");

    // At most one cell grows per item
    a_single_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(grow_vec))
        else $error("more than one cell appended");

    // The final item of a sequence empties the store
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (insert && s_data.last) |=> (count_reg == '0 && valid_vec == '0))
        else $error("store not cleared after final item");
`endif

endmodule

`default_nettype wire
